// File: rtl/order_book_fifo_matcher_unit_macros.svh
// Assertion macros for the order book matcher
`ifndef ORDER_BOOK_FIFO_MATCHER_UNIT_MACROS_SVH
`define ORDER_BOOK_FIFO_MATCHER_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define OBM_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define OBM_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// File: rtl/obm_pkg.sv
// ----------------------------------------------------------------------------
// obm_pkg
// Shared types and constants of the order book matcher.
// ----------------------------------------------------------------------------
package obm_pkg;
  localparam int BOOK_DEPTH = 64;

  typedef struct packed {
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] seq;
  } entry_t;

  typedef struct packed {
    logic        ins;
    logic        bid_side;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] seq;
    logic        pop;
    logic        upd;
    logic [31:0] top_qty;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_INS   = 4'b0010,
    S_MATCH = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;
endpackage

// File: rtl/obm_if.sv
// ----------------------------------------------------------------------------
// obm_in_if / obm_out_if
// Valid/ready channels for orders and results.
// ----------------------------------------------------------------------------
interface obm_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        side;
  logic [31:0] limit_price;
  logic [31:0] order_quantity;
  modport source (output valid, side, limit_price, order_quantity, input ready);
  modport sink (input valid, side, limit_price, order_quantity, output ready);
endinterface

interface obm_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        trade_valid;
  logic [31:0] trade_price;
  logic [31:0] trade_quantity;
  logic        book_full;
  modport source (output valid, trade_valid, trade_price, trade_quantity, book_full,
                  input ready);
  modport sink (input valid, trade_valid, trade_price, trade_quantity, book_full,
                output ready);
endinterface

// File: rtl/obm_cell.sv
// ----------------------------------------------------------------------------
// obm_cell
// One slot of a sorted book; inserts, shifts and pops with its neighbors.
// ----------------------------------------------------------------------------
module obm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  obm_pkg::cell_ctl_t ctl,
  input  logic               is_top,
  input  logic               prev_valid,
  input  obm_pkg::entry_t    prev_entry,
  input  logic               prev_goes_after,
  input  logic               next_valid,
  input  obm_pkg::entry_t    next_entry,
  output logic               valid_o,
  output obm_pkg::entry_t    entry_o,
  output logic               goes_after_o
);
  import obm_pkg::*;

  logic   valid_r, valid_nxt;
  entry_t entry_r, entry_nxt;
  entry_t new_e;

  assign new_e = '{price: ctl.price, qty: ctl.qty, seq: ctl.seq};
  // new order lands after this entry (price-time order)
  assign goes_after_o = valid_r &&
    (ctl.bid_side ? (entry_r.price >= ctl.price) : (entry_r.price <= ctl.price));

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (!goes_after_o) begin
        valid_nxt = valid_r || prev_valid;
        if (is_top || prev_goes_after) begin
          entry_nxt = new_e;
          valid_nxt = 1'b1;
        end else begin
          entry_nxt = prev_entry;
        end
        if (!is_top && !prev_valid) valid_nxt = valid_r;
        if (!is_top && !prev_valid && prev_goes_after) valid_nxt = 1'b1;
      end
    end else if (ctl.pop) begin
      valid_nxt = next_valid;
      entry_nxt = next_entry;
    end else if (ctl.upd && is_top) begin
      entry_nxt.qty = ctl.top_qty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

  assign valid_o = valid_r;
  assign entry_o = entry_r;
endmodule

// File: rtl/obm_chain.sv
// ----------------------------------------------------------------------------
// obm_chain
// Row of book cells forming one sorted side of the book.
// ----------------------------------------------------------------------------
module obm_chain (
  input  logic               clk,
  input  logic               rst_n,
  input  obm_pkg::cell_ctl_t ctl,
  output logic               top_valid,
  output obm_pkg::entry_t    top_entry,
  output logic               full
);
  import obm_pkg::*;

  logic   v   [BOOK_DEPTH+1];
  entry_t e   [BOOK_DEPTH+1];
  logic   ga  [BOOK_DEPTH];

  assign v[BOOK_DEPTH] = 1'b0;
  assign e[BOOK_DEPTH] = '0;

  for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
    obm_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .is_top(i == 0),
      .prev_valid(i == 0 ? 1'b0 : v[(i == 0) ? 0 : i-1]),
      .prev_entry(e[(i == 0) ? 0 : i-1]),
      .prev_goes_after(i == 0 ? 1'b0 : ga[(i == 0) ? 0 : i-1]),
      .next_valid(v[i+1]),
      .next_entry(e[i+1]),
      .valid_o(v[i]),
      .entry_o(e[i]),
      .goes_after_o(ga[i])
    );
  end

  assign top_valid = v[0];
  assign top_entry = e[0];
  assign full      = v[BOOK_DEPTH-1];
endmodule

// File: rtl/order_book_fifo_matcher_unit.sv
// ----------------------------------------------------------------------------
// order_book_fifo_matcher_unit
// Limit order book with price-time priority matching in two cell chains.
// ----------------------------------------------------------------------------
// Usage: orders enter on the in channel (side, limit_price, order_quantity);
// one result item per order leaves on the out channel.
// Each book is a chain of cells kept sorted; an insert shifts all worse cells
// down together, a fill pops or reduces the top cells of both chains.
// Steps per item: accept, insert, one fill per matching pair of chain heads,
// a final compare that finds no match, then the result.
// Zero-quantity and full-book orders skip insert and match.
// One order is worked on at a time; in.ready is high in the idle state.
// The result sits in an output register until taken; a stalled receiver
// holds the block in the result state and no new order is accepted.
// Reset (synchronous, rst_n low) empties both books and clears the sequence
// stamp; no clearing pass is needed since cells carry their own valid bits.
// trade_quantity saturates at all ones; trade_price is the first fill price.
module order_book_fifo_matcher_unit (
  input logic clk,
  input logic rst_n,
  obm_in_if.sink    in_ch,
  obm_out_if.source out_ch
);
  import obm_pkg::*;
`include "order_book_fifo_matcher_unit_macros.svh"

  state_t      state_r, state_nxt;
  logic        side_r;
  logic [31:0] price_r, qty_r, seq_r;
  logic        filled_r;
  logic [31:0] first_r;
  logic [32:0] total_r;
  logic        full_flag_r;
  cell_ctl_t   bctl, actl;
  logic        bv, av, bfull, afull;
  entry_t      be, ae;
  logic        match;
  logic [31:0] m;

  obm_chain u_bid (.clk(clk), .rst_n(rst_n), .ctl(bctl), .top_valid(bv),
                   .top_entry(be), .full(bfull));
  obm_chain u_ask (.clk(clk), .rst_n(rst_n), .ctl(actl), .top_valid(av),
                   .top_entry(ae), .full(afull));

  assign match = bv && av && (be.price == ae.price);
  assign m = (be.qty < ae.qty) ? be.qty : ae.qty;

  always_comb begin
    bctl = '0;
    bctl.bid_side = 1'b1;
    bctl.price = price_r;
    bctl.qty = qty_r;
    bctl.seq = seq_r;
    actl = bctl;
    actl.bid_side = 1'b0;
    if (state_r == S_INS) begin
      bctl.ins = !side_r;
      actl.ins = side_r;
    end
    if (state_r == S_MATCH && match) begin
      bctl.pop = (be.qty == m);
      actl.pop = (ae.qty == m);
      bctl.upd = 1'b1;
      actl.upd = 1'b1;
      bctl.top_qty = be.qty - m;
      actl.top_qty = ae.qty - m;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_ch.valid) begin
        if (in_ch.order_quantity == 32'd0 ||
            (in_ch.side ? afull : bfull)) state_nxt = S_OUT;
        else state_nxt = S_INS;
      end
      S_INS:   state_nxt = S_MATCH;
      S_MATCH: if (!match) state_nxt = S_OUT;
      S_OUT:   if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seq_r <= 32'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INS) seq_r <= seq_r + 32'd1;
    end
    if (state_r == S_IDLE && in_ch.valid) begin
      side_r <= in_ch.side;
      price_r <= in_ch.limit_price;
      qty_r <= in_ch.order_quantity;
      filled_r <= 1'b0;
      total_r <= '0;
      first_r <= '0;
      full_flag_r <= (in_ch.order_quantity != 32'd0) && (in_ch.side ? afull : bfull);
    end
    if (state_r == S_MATCH && match) begin
      if (!filled_r) first_r <= ae.price;
      filled_r <= 1'b1;
      total_r <= (total_r + {1'b0, m} > 33'h0_FFFF_FFFF) ? 33'h0_FFFF_FFFF
                 : total_r + {1'b0, m};
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.trade_valid = filled_r;
  assign out_ch.trade_price = first_r;
  assign out_ch.trade_quantity = total_r[31:0];
  assign out_ch.book_full = full_flag_r;

  `OBM_ASSERT_IMP(a_no_cross, clk, rst_n, state_r == S_IDLE, !match)
  `OBM_ASSERT_IMP(a_flags, clk, rst_n, out_ch.valid, !(filled_r && full_flag_r))
  `OBM_ASSERT_NXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule

// File: test/order_book_fifo_matcher_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_book_fifo_matcher_unit_test
// Drives limit orders into the matcher and checks every result item against
// a price-time priority book model kept in queues. A short directed table
// runs first, then random orders mixing a narrow price band, book-filling
// bursts, drains of the resting top and noise, under several idling phases.
// ----------------------------------------------------------------------------
module order_book_fifo_matcher_unit_test;
  import obm_pkg::*;

  localparam int RANDOM_ORDERS = 1100;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_LEN     = 280;

  typedef struct packed {
    logic        trade_valid;
    logic [31:0] trade_price;
    logic [31:0] trade_quantity;
    logic        book_full;
  } trade_t;

  typedef struct packed {
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
    logic        typed;
    trade_t      trade;
  } order_row_t;

  typedef enum int {
    MIX_BAND, MIX_FILL, MIX_DRAIN, MIX_NOISE
  } mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  obm_in_if  in_ch (clk);
  obm_out_if out_ch (clk);

  order_book_fifo_matcher_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [31:0] bid_px[$], bid_qt[$], ask_px[$], ask_qt[$];
  trade_t      pending_trades[$];
  order_row_t  order_table[$];

  int   orders_sent = 0;
  int   mismatches = 0;
  int   cycles = 0;
  int   phase = 0;
  int   burst_left = 0;
  mix_t burst_mix = MIX_BAND;
  bit   stim_done = 1'b0;
  logic [31:0] fill_side;

  function automatic trade_t match_order(logic side, logic [31:0] price, logic [31:0] qty);
    trade_t      tr;
    int          pos;
    logic [63:0] total;
    logic [31:0] m;
    tr = '0;
    total = '0;
    if (qty == 0) return tr;
    if (side == 1'b0) begin
      if (bid_px.size() >= BOOK_DEPTH) begin
        tr.book_full = 1'b1;
        return tr;
      end
      pos = 0;
      while (pos < bid_px.size() && bid_px[pos] >= price) pos++;
      bid_px.insert(pos, price);
      bid_qt.insert(pos, qty);
    end else begin
      if (ask_px.size() >= BOOK_DEPTH) begin
        tr.book_full = 1'b1;
        return tr;
      end
      pos = 0;
      while (pos < ask_px.size() && ask_px[pos] <= price) pos++;
      ask_px.insert(pos, price);
      ask_qt.insert(pos, qty);
    end
    while (bid_px.size() > 0 && ask_px.size() > 0 && bid_px[0] == ask_px[0]) begin
      m = (bid_qt[0] < ask_qt[0]) ? bid_qt[0] : ask_qt[0];
      if (!tr.trade_valid) begin
        tr.trade_valid = 1'b1;
        tr.trade_price = ask_px[0];
      end
      total += m;
      bid_qt[0] -= m;
      ask_qt[0] -= m;
      if (bid_qt[0] == 0) begin
        void'(bid_px.pop_front());
        void'(bid_qt.pop_front());
      end
      if (ask_qt[0] == 0) begin
        void'(ask_px.pop_front());
        void'(ask_qt.pop_front());
      end
    end
    if (tr.trade_valid) tr.trade_quantity = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    return tr;
  endfunction

  function automatic logic [31:0] pick_qty();
    case ($urandom_range(0, 9))
      0: return 32'hFFFF_FFFF;
      1: return $urandom_range(1, 32'hFFFF_FFFF);
      2: return 32'd1;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic order_row_t next_order();
    order_row_t o;
    o = '0;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: burst_mix = MIX_BAND;
        5: burst_mix = MIX_FILL;
        6, 7: burst_mix = MIX_DRAIN;
        default: burst_mix = MIX_NOISE;
      endcase
      burst_left = (burst_mix == MIX_FILL) ? 70 : $urandom_range(4, 20);
      fill_side = $urandom_range(0, 1);
    end
    burst_left--;
    case (burst_mix)
      MIX_BAND: begin
        o.side = $urandom_range(0, 1);
        o.price = 1000 + $urandom_range(0, 7);
        o.qty = pick_qty();
      end
      MIX_FILL: begin
        o.side = fill_side[0];
        o.price = 5000 + $urandom_range(0, 200);
        o.qty = $urandom_range(1, 1000);
      end
      MIX_DRAIN: begin
        o.side = $urandom_range(0, 1);
        if (o.side == 1'b1 && bid_px.size() > 0) o.price = bid_px[0];
        else if (o.side == 1'b0 && ask_px.size() > 0) o.price = ask_px[0];
        else o.price = 1000;
        o.qty = pick_qty();
      end
      default: begin
        o.side = $urandom_range(0, 1);
        o.price = $urandom();
        o.qty = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom();
      end
    endcase
    return o;
  endfunction

  function automatic order_row_t row(logic side, logic [31:0] price, logic [31:0] qty,
                                     logic typed, trade_t tr);
    order_row_t r;
    r.side = side;
    r.price = price;
    r.qty = qty;
    r.typed = typed;
    r.trade = tr;
    return r;
  endfunction

  function automatic void add_row(order_row_t r);
    order_table.insert(order_table.size(), r);
  endfunction

  initial begin
    add_row(row(1'b0, 32'd0, 32'd1, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b0}));
    add_row(row(1'b1, 32'd0, 32'd1, 1'b1, '{1'b1, 32'd0, 32'd1, 1'b0}));
    add_row(row(1'b0, '1, '1, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b0}));
    add_row(row(1'b1, '1, '1, 1'b1, '{1'b1, '1, '1, 1'b0}));
    add_row(row(1'b0, 32'd5, 32'd0, 1'b1, '0));
    add_row(row(1'b1, 32'd5, 32'd0, 1'b1, '0));
    add_row(row(1'b0, 32'd100, 32'd10, 1'b0, '0));
    add_row(row(1'b0, 32'd100, 32'd20, 1'b0, '0));
    add_row(row(1'b1, 32'd100, 32'd25, 1'b0, '0));
    add_row(row(1'b1, 32'd100, 32'd5, 1'b0, '0));
    add_row(row(1'b1, 32'd200, 32'd7, 1'b0, '0));
    add_row(row(1'b0, 32'd300, 32'd3, 1'b0, '0));
    add_row(row(1'b0, 32'd200, 32'd9, 1'b0, '0));
    add_row(row(1'b1, 32'd300, 32'h8000_0000, 1'b0, '0));
    add_row(row(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0));
    add_row(row(1'b1, 32'h8000_0000, 32'hFFFF_FFFE, 1'b0, '0));
  end

  // order driver
  always @(posedge clk) begin
    order_row_t o;
    trade_t     tr;
    bit         taken;
    int         idle_pct;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.side <= 1'b0;
      in_ch.limit_price <= '0;
      in_ch.order_quantity <= '0;
    end else begin
      taken = in_ch.valid && in_ch.ready;
      if (taken) begin
        tr = match_order(in_ch.side, in_ch.limit_price, in_ch.order_quantity);
        if (orders_sent < order_table.size() && order_table[orders_sent].typed)
          tr = order_table[orders_sent].trade;
        pending_trades.insert(pending_trades.size(), tr);
        orders_sent++;
        phase = (orders_sent / PHASE_LEN) % 4;
      end
      if (!in_ch.valid || taken) begin
        idle_pct = (phase == 1) ? 74 : (phase == 3) ? 18 : 0;
        if (orders_sent >= order_table.size() + RANDOM_ORDERS) begin
          in_ch.valid <= 1'b0;
          stim_done <= 1'b1;
        end else if ($urandom_range(0, 99) < idle_pct) begin
          in_ch.valid <= 1'b0;
        end else begin
          o = (orders_sent < order_table.size()) ? order_table[orders_sent] : next_order();
          in_ch.valid <= 1'b1;
          in_ch.side <= o.side;
          in_ch.limit_price <= o.price;
          in_ch.order_quantity <= o.qty;
        end
      end
    end
  end

  // result checker and receiver
  always @(posedge clk) begin
    trade_t got, want;
    int     stall_pct;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.trade_valid, out_ch.trade_price, out_ch.trade_quantity,
                out_ch.book_full};
        if (pending_trades.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", got);
        end else begin
          want = pending_trades.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, actual %p", want, got);
          end
        end
      end
      stall_pct = (phase == 2) ? 74 : (phase == 3) ? 18 : 0;
      out_ch.ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    wait (pending_trades.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_trades.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
